>>> hw/rtl/byte_stack_multiwidth_defines.svh
// ----------------------------------------------------------------------------
// byte stack assertion macros
// shared concurrent checks, clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef BYTE_STACK_MULTIWIDTH_DEFINES_SVH
`define BYTE_STACK_MULTIWIDTH_DEFINES_SVH

// same-cycle implication
`define BSM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error(msg);

// next-cycle implication
`define BSM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> cons) \
		else $error(msg);

`endif

>>> hw/rtl/bsm_pkg.sv
// ----------------------------------------------------------------------------
// bsm_pkg
// shared types and codes of the multi-width byte stack
// ----------------------------------------------------------------------------
package bsm_pkg;

	localparam int FILL_W = 9;

	// request codes
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	localparam logic [1:0] SZ_ONE = 2'd0;
	localparam logic [1:0] SZ_TWO = 2'd1;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	// request context carried to the merge stage
	typedef struct packed {
		logic              valid;
		logic              ok;
		logic              pop;
		logic              little;
		logic [2:0]        nbytes;
		logic [1:0]        base_lo;
		status_t           status;
		logic [FILL_W-1:0] fill;
	} merge_ctl_t;

	// size code three moves four bytes like code two
	function automatic logic [2:0] size_bytes(input logic [1:0] code);
		logic [2:0] n;
		case (code)
			SZ_ONE:  n = 3'd1;
			SZ_TWO:  n = 3'd2;
			default: n = 3'd4;
		endcase
		return n;
	endfunction

endpackage

>>> hw/rtl/bsm_lane.sv
// ----------------------------------------------------------------------------
// bsm_lane
// one byte bank of the stack, holding every fourth byte address
// ----------------------------------------------------------------------------
module bsm_lane #(
	parameter int ROWS = 64
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] row,
	input  logic [7:0]                             wdata,
	output logic [7:0]                             rdata
);

	logic [7:0] mem [ROWS];
	logic [7:0] rdata_q;

	// registered read, old data on a same-row write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[row] <= wdata;
		end
		rdata_q <= mem[row];
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/bsm_merge.sv
// ----------------------------------------------------------------------------
// bsm_merge
// reassembles popped bytes from the four banks and registers the result beat
// ----------------------------------------------------------------------------
module bsm_merge
	import bsm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  merge_ctl_t           ctl_s1,
	input  logic [3:0][7:0]      lane_rdata,
	output logic                 done,
	output status_t              status,
	output logic [31:0]          popped_value,
	output logic [FILL_W-1:0]    fill_level
);

	logic [31:0]       value_d;
	logic              done_q;
	status_t           status_q;
	logic [31:0]       value_q;
	logic [FILL_W-1:0] fill_q;

	always_comb begin
		logic [1:0] bank;
		logic [1:0] sel;
		value_d = '0;
		for (int i = 0; i < 4; i++) begin
			bank = ctl_s1.base_lo + 2'(i);
			sel  = ctl_s1.little ? 2'(i) : 2'(ctl_s1.nbytes - 3'd1 - 3'(i));
			if (ctl_s1.pop && ctl_s1.ok && (3'(i) < ctl_s1.nbytes)) begin
				value_d = value_d | (32'(lane_rdata[bank]) << {sel, 3'b000});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.valid) begin
			status_q <= ctl_s1.status;
			value_q  <= value_d;
			fill_q   <= ctl_s1.fill;
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign popped_value = value_q;
	assign fill_level   = fill_q;

endmodule

>>> hw/rtl/byte_stack_multiwidth.sv
// ----------------------------------------------------------------------------
// byte_stack_multiwidth
// byte-wide lifo with one-, two- and four-byte push and pop in either order
// ----------------------------------------------------------------------------
// result: done beat is registered in bsm_merge, behind ctl_s1 and the bank reads
// throughput: one request per cycle, busy stays low; four address-interleaved
//   byte banks each take one byte of any access in the accept cycle
// reset: fill count clears to zero and capacity to 256; bank contents are left
//   as they are, no clearing pass; done cannot be held off by the receiver
// ----------------------------------------------------------------------------
`include "byte_stack_multiwidth_defines.svh"

module byte_stack_multiwidth
	import bsm_pkg::*;
#(
	parameter int DEPTH = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	// request beat
	input  logic              start,
	output logic              busy,
	input  logic              op,
	input  logic [1:0]        size_code,
	input  logic              little_endian,
	input  logic [31:0]       push_value,
	// capacity register
	input  logic              cfg_we,
	input  logic [FILL_W-1:0] cfg_wdata,
	// result beat
	output logic              done,
	output logic [1:0]        status,
	output logic [31:0]       popped_value,
	output logic [FILL_W-1:0] fill_level
);

	// capacity in effect never exceeds the store nor the fill counter range
	localparam int CAP_LIMIT = (DEPTH > (1 << FILL_W) - 1) ? (1 << FILL_W) - 1 : DEPTH;
	localparam int ROWS      = (DEPTH + 3) / 4;
	localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;

	logic [FILL_W-1:0] cap_q;
	logic [FILL_W-1:0] fill_q;
	merge_ctl_t        ctl_s1;

	logic              acc;
	logic              is_pop;
	logic [2:0]        nbytes;
	logic [FILL_W-1:0] eff_cap;
	logic [FILL_W:0]   push_sum;
	logic              ovf;
	logic              unf;
	logic              ok;
	logic [FILL_W-1:0] base;
	logic [FILL_W-1:0] fill_next;
	status_t           req_status;
	status_t           res_status;

	logic [3:0]            lane_we;
	logic [3:0][ROW_W-1:0] lane_row;
	logic [3:0][7:0]       lane_wdata;
	logic [3:0][7:0]       lane_rdata;

	// the whole request is decided at the accept edge, so there is never back-pressure
	assign busy = 1'b0;
	assign acc  = start && !busy;

	// request decode and bounds checks
	assign is_pop   = (op == OP_POP);
	assign nbytes   = size_bytes(size_code);
	assign eff_cap  = (cap_q > FILL_W'(CAP_LIMIT)) ? FILL_W'(CAP_LIMIT) : cap_q;
	assign push_sum = {1'b0, fill_q} + (FILL_W + 1)'(nbytes);
	assign ovf      = push_sum > {1'b0, eff_cap};
	assign unf      = fill_q < FILL_W'(nbytes);
	assign ok       = is_pop ? !unf : !ovf;

	// lowest byte address touched: new bytes sit on top of the fill,
	// popped bytes are the top nbytes below it
	assign base = is_pop ? (fill_q - FILL_W'(nbytes)) : fill_q;

	always_comb begin
		fill_next = fill_q;
		if (ok) begin
			fill_next = is_pop ? base : push_sum[FILL_W-1:0];
		end
	end

	always_comb begin
		if (ok) begin
			req_status = ST_DONE;
		end else if (is_pop) begin
			req_status = ST_UNDERFLOW;
		end else begin
			req_status = ST_OVERFLOW;
		end
	end

	// lane b holds byte addresses with addr mod 4 == b; the k-th byte of
	// this access lands in lane (base + k) mod 4
	for (genvar b = 0; b < 4; b++) begin : g_lane
		logic [1:0]    k;
		logic [1:0]    sel;
		logic          in_use;
		logic [FILL_W:0] addr;

		assign k      = 2'(b) - base[1:0];
		assign in_use = {1'b0, k} < nbytes;
		// big-endian puts the most significant byte at the lowest address
		assign sel    = little_endian ? k : 2'(nbytes - 3'd1 - {1'b0, k});
		assign addr   = {1'b0, base} + (FILL_W + 1)'(k);

		assign lane_we[b]    = acc && ok && !is_pop && in_use;
		assign lane_row[b]   = ROW_W'(addr >> 2);
		assign lane_wdata[b] = push_value[{sel, 3'b000} +: 8];

		bsm_lane #(
			.ROWS (ROWS)
		) u_lane (
			.clk   (clk),
			.wr_en (lane_we[b]),
			.row   (lane_row[b]),
			.wdata (lane_wdata[b]),
			.rdata (lane_rdata[b])
		);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= FILL_W'(256);
			fill_q <= '0;
			ctl_s1 <= '0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (acc) begin
				fill_q <= fill_next;
			end
			ctl_s1.valid   <= acc;
			ctl_s1.ok      <= ok;
			ctl_s1.pop     <= is_pop;
			ctl_s1.little  <= little_endian;
			ctl_s1.nbytes  <= nbytes;
			ctl_s1.base_lo <= base[1:0];
			ctl_s1.status  <= req_status;
			ctl_s1.fill    <= fill_next;
		end
	end

	// byte reassembly and result register
	bsm_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl_s1       (ctl_s1),
		.lane_rdata   (lane_rdata),
		.done         (done),
		.status       (res_status),
		.popped_value (popped_value),
		.fill_level   (fill_level)
	);

	assign status = res_status;

	// checks
	`BSM_ASSERT_NOW(a_fill_bound, 1'b1, (fill_q <= FILL_W'(CAP_LIMIT)), "fill above store limit")
	`BSM_ASSERT_NEXT(a_reject_holds, (acc && !ok), (fill_q == $past(fill_q)), "rejected request moved fill")
	`BSM_ASSERT_NOW(a_result_timing, acc, ##2 done, "missing result beat after request")
	`BSM_ASSERT_NOW(a_zero_on_fail, (done && res_status != ST_DONE), (popped_value == 32'd0), "rejected request returned data")

endmodule

>>> tb/byte_stack_multiwidth_test.sv
// ----------------------------------------------------------------------------
// byte_stack_multiwidth_test
// self-checking bench for the multi-width byte stack: directed byte order and
// capacity corner cases, then bursty random push and pop traffic over several
// capacity settings, every result beat checked against an in-bench stack model
// ----------------------------------------------------------------------------
module byte_stack_multiwidth_test;
	timeunit 1ns;
	timeprecision 1ps;

	import bsm_pkg::*;

	localparam int STACK_DEPTH = 256;
	// size codes the package leaves unnamed, both move four bytes
	localparam logic [1:0] SZ_FOUR     = 2'd2;
	localparam logic [1:0] SZ_FOUR_ALT = 2'd3;
	// result beat lands behind the ctl_s1 and merge registers, leave some slack
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES  = 8;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int PRINT_LIMIT   = 30;

	// one result beat as the stack should report it
	typedef struct packed {
		status_t           status;
		logic [31:0]       value;
		logic [FILL_W-1:0] fill;
	} stack_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic              op = OP_PUSH;
	logic [1:0]        size_code = SZ_ONE;
	logic              little_endian = 1'b0;
	logic [31:0]       push_value = '0;
	logic              cfg_we = 1'b0;
	logic [FILL_W-1:0] cfg_wdata = '0;
	logic              done;
	logic [1:0]        status;
	logic [31:0]       popped_value;
	logic [FILL_W-1:0] fill_level;

	byte_stack_multiwidth #(
		.DEPTH(STACK_DEPTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.size_code    (size_code),
		.little_endian(little_endian),
		.push_value   (push_value),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.done         (done),
		.status       (status),
		.popped_value (popped_value),
		.fill_level   (fill_level)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------------
	// stack model: own copy of the byte store, fill and capacity
	// ------------------------------------------------------------------------
	logic [7:0] model_bytes [STACK_DEPTH];
	int         model_fill = 0;
	int         model_capacity = 256;

	// expected result beats, oldest first
	stack_result_t pending_results [$];

	// run bookkeeping
	int  n_errors = 0;
	int  n_sent = 0;
	int  n_checked = 0;
	int  n_pushes = 0;
	int  n_pops = 0;
	int  n_overflows = 0;
	int  n_underflows = 0;
	int  n_cfg_writes = 0;
	int  deepest_fill = 0;
	int  cycles = 0;

	// sender pacing: start as last driven, burst state
	logic start_q = 1'b0;
	logic gaps_on = 1'b1;
	int   burst_left = 8;

	// apply one request to the model and return the beat it should produce
	function automatic stack_result_t predict_request(input logic req_op,
			input logic [1:0] code, input logic little, input logic [31:0] value);
		int            nbytes;
		int            limit;
		int            sel;
		int            base;
		stack_result_t r;
		nbytes = (code == SZ_ONE) ? 1 : (code == SZ_TWO) ? 2 : 4;
		// capacity beyond the store is clipped to the store depth
		limit = (model_capacity > STACK_DEPTH) ? STACK_DEPTH : model_capacity;
		r.status = ST_DONE;
		r.value = '0;
		if (req_op == OP_PUSH) begin
			if (model_fill + nbytes > limit) begin
				r.status = ST_OVERFLOW;
			end else begin
				// big-endian stores the msb first so the lsb ends on top
				for (int i = 0; i < nbytes; i++) begin
					sel = little ? i : nbytes - 1 - i;
					model_bytes[model_fill + i] = value[8*sel +: 8];
				end
				model_fill += nbytes;
			end
		end else begin
			if (model_fill < nbytes) begin
				r.status = ST_UNDERFLOW;
			end else begin
				// rebuild in mirror order, narrower pops stay zero-extended
				base = model_fill - nbytes;
				for (int i = 0; i < nbytes; i++) begin
					sel = little ? i : nbytes - 1 - i;
					r.value[8*sel +: 8] = model_bytes[base + i];
				end
				model_fill = base;
			end
		end
		r.fill = model_fill[FILL_W-1:0];
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------------
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		n_errors++;
		// keep the log short when something is badly broken
		if (n_errors <= PRINT_LIMIT)
			$display("mismatch at %0t ns: %s, got %h, want %h", $realtime, what, got, want);
	endtask

	// every done beat is taken at the edge that ends it
	always @(posedge clk) begin
		stack_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result beat with nothing pending", popped_value, '0);
			end else begin
				want = pending_results.pop_front();
				n_checked++;
				if (status !== want.status)
					report_mismatch("status", 32'(status), 32'(want.status));
				if (popped_value !== want.value)
					report_mismatch("popped_value", popped_value, want.value);
				if (fill_level !== want.fill)
					report_mismatch("fill_level", 32'(fill_level), 32'(want.fill));
			end
		end
	end

	// hard stop if the stack hangs
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending",
				cycles, pending_results.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// sender side
	// ------------------------------------------------------------------------
	// lower start once, only if it is up
	task automatic stop_sender();
		if (start_q) begin
			start <= 1'b0;
			start_q = 1'b0;
		end
	endtask

	// drive one request beat and hold it until the stack takes it
	task automatic send_request(input logic req_op, input logic [1:0] code,
			input logic little, input logic [31:0] value, output status_t outcome);
		stack_result_t r;
		op <= req_op;
		size_code <= code;
		little_endian <= little;
		push_value <= value;
		// start may already be high from the previous beat of a burst
		if (!start_q)
			start <= 1'b1;
		start_q = 1'b1;
		do @(posedge clk); while (busy);
		r = predict_request(req_op, code, little, value);
		pending_results.push_back(r);
		n_sent++;
		case (r.status)
			ST_OVERFLOW:  n_overflows++;
			ST_UNDERFLOW: n_underflows++;
			default: begin
				if (req_op == OP_PUSH)
					n_pushes++;
				else
					n_pops++;
			end
		endcase
		if (model_fill > deepest_fill)
			deepest_fill = model_fill;
		outcome = r.status;
	endtask

	// bursts of back-to-back beats with random gaps, the odd gap a long one
	task automatic pace_sender();
		int gap;
		if (gaps_on) begin
			burst_left--;
			if (burst_left <= 0) begin
				stop_sender();
				gap = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 4);
				repeat (gap) @(posedge clk);
				burst_left = $urandom_range(1, 24);
			end
		end
	endtask

	// capacity is only written with the stack idle and all results in
	task automatic write_capacity(input int cap);
		stop_sender();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= cap[FILL_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		model_capacity = cap & 'h1FF;
		n_cfg_writes++;
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	// byte order of every size, both endians, value extremes, size code three
	task automatic test_byte_order();
		status_t outcome;
		// pop from an empty stack
		send_request(OP_POP, SZ_FOUR, 1'b0, '0, outcome);
		pace_sender();
		// same order both ways gives the value back
		send_request(OP_PUSH, SZ_FOUR, 1'b0, 32'h1234_5678, outcome);
		send_request(OP_POP, SZ_FOUR, 1'b0, '0, outcome);
		pace_sender();
		// little-endian push read big-endian comes back byte-swapped
		send_request(OP_PUSH, SZ_FOUR, 1'b1, 32'hA1B2_C3D4, outcome);
		send_request(OP_POP, SZ_FOUR, 1'b0, '0, outcome);
		pace_sender();
		// narrow pushes use only the low bytes
		send_request(OP_PUSH, SZ_TWO, 1'b0, 32'hFFFF_BEEF, outcome);
		send_request(OP_PUSH, SZ_ONE, 1'b1, 32'hFFFF_FFFF, outcome);
		send_request(OP_PUSH, SZ_FOUR_ALT, 1'b1, 32'h0000_0000, outcome);
		send_request(OP_PUSH, SZ_TWO, 1'b1, 32'h0000_8001, outcome);
		pace_sender();
		// pops straddle the earlier pushes
		send_request(OP_POP, SZ_ONE, 1'b0, '1, outcome);
		send_request(OP_POP, SZ_TWO, 1'b0, '1, outcome);
		send_request(OP_POP, SZ_FOUR_ALT, 1'b1, '0, outcome);
		// two bytes left, a four-byte pop must bounce
		send_request(OP_POP, SZ_FOUR, 1'b1, '0, outcome);
		send_request(OP_POP, SZ_TWO, 1'b1, '0, outcome);
		pace_sender();
	endtask

	// capacity zero, an exact fit, clipping above depth, capacity below fill
	task automatic test_capacity_edges();
		status_t outcome;
		write_capacity(0);
		send_request(OP_PUSH, SZ_ONE, 1'b0, 32'h0000_00A5, outcome);
		send_request(OP_POP, SZ_ONE, 1'b0, '0, outcome);
		write_capacity(3);
		send_request(OP_PUSH, SZ_TWO, 1'b0, 32'h0000_C35A, outcome);
		send_request(OP_PUSH, SZ_TWO, 1'b1, 32'h0000_1111, outcome);
		send_request(OP_PUSH, SZ_ONE, 1'b1, 32'h0000_007E, outcome);
		send_request(OP_PUSH, SZ_ONE, 1'b0, 32'h0000_0001, outcome);
		// all ones in the register, clipped to the store depth
		write_capacity(511);
		send_request(OP_PUSH, SZ_FOUR, 1'b0, 32'hDEAD_0F0F, outcome);
		// now seven bytes held against a capacity of two
		write_capacity(2);
		send_request(OP_PUSH, SZ_ONE, 1'b0, 32'h0000_0033, outcome);
		send_request(OP_POP, SZ_FOUR, 1'b1, '0, outcome);
		send_request(OP_POP, SZ_ONE, 1'b0, '0, outcome);
		send_request(OP_PUSH, SZ_ONE, 1'b1, 32'h0000_0044, outcome);
		send_request(OP_POP, SZ_TWO, 1'b0, '0, outcome);
		send_request(OP_PUSH, SZ_TWO, 1'b1, 32'h0000_ABCD, outcome);
		pace_sender();
	endtask

	// random traffic that swings the stack between empty and full
	task automatic test_random_traffic();
		int         caps [8] = '{511, 256, 1, 0, 300, 64, 4, 0};
		int         lens [8] = '{200, 150, 40, 30, 120, 120, 60, 130};
		logic       filling;
		logic       do_pop;
		logic [1:0] code;
		logic [31:0] value;
		status_t    outcome;
		caps[7] = $urandom_range(5, 255);
		filling = 1'b1;
		for (int p = 0; p < 8; p++) begin
			write_capacity(caps[p]);
			// first phase runs flat out, the rest in bursts
			gaps_on = (p != 0);
			burst_left = $urandom_range(1, 24);
			for (int k = 0; k < lens[p]; k++) begin
				// mostly pushes while filling, mostly pops while draining
				do_pop = filling ? ($urandom_range(0, 99) < 12) : ($urandom_range(0, 99) >= 12);
				code = 2'($urandom_range(0, 3));
				case ($urandom_range(0, 15))
					0:       value = '0;
					1:       value = '1;
					default: value = $urandom;
				endcase
				send_request(do_pop ? OP_POP : OP_PUSH, code, 1'($urandom_range(0, 1)), value,
					outcome);
				pace_sender();
				// turn around at either end, now and then on a whim
				if (outcome == ST_OVERFLOW)
					filling = 1'b0;
				else if (outcome == ST_UNDERFLOW)
					filling = 1'b1;
				if ($urandom_range(0, 49) == 0)
					filling = !filling;
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// sequencing
	// ------------------------------------------------------------------------
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_byte_order();
		test_capacity_edges();
		test_random_traffic();

		// let the last beats come out, bounded
		stop_sender();
		for (int w = 0; w < 64 && pending_results.size() != 0; w++)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never delivered", 32'(pending_results.size()), '0);

		$display("covered %0d requests: %0d pushes, %0d pops, %0d overflow and %0d underflow rejects",
			n_sent, n_pushes, n_pops, n_overflows, n_underflows);
		$display("%0d capacity writes, deepest fill %0d bytes, %0d beats checked, %0d mismatches",
			n_cfg_writes, deepest_fill, n_checked, n_errors);
		if (n_errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/bsm_pkg.sv
hw/rtl/bsm_lane.sv
hw/rtl/bsm_merge.sv
hw/rtl/byte_stack_multiwidth.sv
tb/byte_stack_multiwidth_test.sv
